// ----- rtl/trc_pkg.sv -----
package trc_pkg;
  localparam int MaxFrameWidthDef = 256;
  localparam int MaxFrameHeightDef = 256;
  localparam int CfgW = 9;      // frame size register width
  localparam int CoordW = 20;   // pixel coordinate, 8 fraction bits
  localparam int OpW = 21;      // multiplier operand width
  localparam int ProdW = 42;
  localparam int AccW = 48;     // edge function accumulators
  localparam int StepW = 4;
  localparam logic [StepW-1:0] SetupLast = 4'd14;

  localparam logic CmdDraw = 1'b0;
  localparam logic CmdRead = 1'b1;

  localparam logic RegWidth = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef struct packed {
    logic             clear_en;
    logic             capture;
    logic             setup_en;
    logic [StepW-1:0] step;
    logic             scan_en;
    logic             out_load;
  } trc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic degenerate;
    logic scan_last;
    logic out_free;
  } trc_status_t;
endpackage

// ----- rtl/trc_ram.sv -----
module trc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/trc_ctrl.sv -----
module trc_ctrl import trc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        command,
  input  trc_status_t status,
  output trc_cmd_t    cmd,
  output logic        in_stall
);
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state, state_next;
  logic [StepW-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next = step;
    cmd = '0;
    cmd.step = step;
    in_stall = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_next = '0;
          state_next = (command == CmdRead) ? S_READ : S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup_en = 1'b1;
        if (step == SetupLast) begin
          state_next = status.degenerate ? S_FINISH : S_SCAN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) state_next = S_FINISH;
      end
      S_READ: state_next = S_FINISH;
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end
endmodule

// ----- rtl/trc_dp.sv -----
module trc_dp import trc_pkg::*; #(
  parameter int MAX_FRAME_WIDTH = MaxFrameWidthDef,
  parameter int MAX_FRAME_HEIGHT = MaxFrameHeightDef
) (
  input  logic               clk,
  input  logic               rst,
  input  trc_cmd_t           cmd,
  output trc_status_t        status,
  input  logic [CfgW-1:0]    frame_width,
  input  logic [CfgW-1:0]    frame_height,
  input  logic               command,
  input  logic signed [15:0] vert_a_x,
  input  logic signed [15:0] vert_a_y,
  input  logic signed [15:0] vert_b_x,
  input  logic signed [15:0] vert_b_y,
  input  logic signed [15:0] vert_c_x,
  input  logic signed [15:0] vert_c_y,
  input  logic [15:0]        read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               reply_kind,
  output logic               pixel_lit
);
  localparam int Store = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
  localparam int AddrW = (Store > 1) ? $clog2(Store) : 1;
  localparam int RamDepth = (Store > 1) ? Store : 2;

  logic [CfgW-1:0] w_eff, h_eff;
  logic cmd_q;
  logic signed [15:0] vin [6];
  logic [15:0] ridx;
  logic signed [CoordW-1:0] crd [6];  // ax, ay, bx, by, cx, cy
  logic signed [OpW-1:0] e0x, e0y, e1x, e1y, mul_a, mul_b;
  logic signed [ProdW-1:0] prod, p1, rnd;
  logic signed [AccW-1:0] d, nb, ng, na, nb_r, ng_r, na_r;
  logic signed [AccW-1:0] dnb_c, dng_c, dna_c, dnb_r, dng_r, dna_r;
  logic [CfgW-1:0] col, row;
  logic [AddrW-1:0] pix;
  logic covered, in_range, ram_we, ram_q;

  always_comb begin
    if (frame_width == '0) w_eff = CfgW'(1);
    else if (32'(frame_width) > MAX_FRAME_WIDTH) w_eff = CfgW'(MAX_FRAME_WIDTH);
    else w_eff = frame_width;
    if (frame_height == '0) h_eff = CfgW'(1);
    else if (32'(frame_height) > MAX_FRAME_HEIGHT) h_eff = CfgW'(MAX_FRAME_HEIGHT);
    else h_eff = frame_height;
  end

  assign e0x = OpW'(crd[2]) - OpW'(crd[0]);
  assign e0y = OpW'(crd[3]) - OpW'(crd[1]);
  assign e1x = OpW'(crd[4]) - OpW'(crd[0]);
  assign e1y = OpW'(crd[5]) - OpW'(crd[1]);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      4'd0, 4'd2, 4'd4: begin
        mul_a = OpW'({1'b0, w_eff});
        mul_b = OpW'(vin[cmd.step[2:0]]) + OpW'(16384);
      end
      4'd1, 4'd3, 4'd5: begin
        mul_a = OpW'({1'b0, h_eff});
        mul_b = OpW'(vin[cmd.step[2:0]]) + OpW'(16384);
      end
      4'd7:  begin mul_a = e0x; mul_b = e1y; end
      4'd8:  begin mul_a = e0y; mul_b = e1x; end
      4'd9:  begin mul_a = OpW'(crd[0]); mul_b = e1y; end
      4'd10: begin mul_a = OpW'(crd[1]); mul_b = e1x; end
      4'd11: begin mul_a = e0x; mul_b = OpW'(crd[1]); end
      4'd12: begin mul_a = e0y; mul_b = OpW'(crd[0]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign rnd = prod + ProdW'(64);

  assign covered = d[AccW-1]
    ? ((nb[AccW-1] || nb == '0) && (ng[AccW-1] || ng == '0) && (na[AccW-1] || na == '0))
    : (!nb[AccW-1] && !ng[AccW-1] && !na[AccW-1]);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.capture) begin
      cmd_q <= command;
      vin[0] <= vert_a_x;
      vin[1] <= vert_a_y;
      vin[2] <= vert_b_x;
      vin[3] <= vert_b_y;
      vin[4] <= vert_c_x;
      vin[5] <= vert_c_y;
      ridx <= read_index;
    end
    if (cmd.setup_en) begin
      case (cmd.step)
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6:
          crd[3'(cmd.step - 1'b1)] <= rnd[CoordW+6:7] - CoordW'(128);
        4'd8, 4'd10, 4'd12: p1 <= prod;
        4'd9:  d <= AccW'(p1) - AccW'(prod);
        4'd11: nb <= AccW'(prod) - AccW'(p1);
        4'd13: ng <= AccW'(prod) - AccW'(p1);
        4'd14: begin
          na <= d - nb - ng;
          na_r <= d - nb - ng;
          nb_r <= nb;
          ng_r <= ng;
          dnb_c <= AccW'(e1y) <<< 8;
          dng_c <= -(AccW'(e0y) <<< 8);
          dna_c <= (AccW'(e0y) - AccW'(e1y)) <<< 8;
          dnb_r <= -(AccW'(e1x) <<< 8);
          dng_r <= AccW'(e0x) <<< 8;
          dna_r <= (AccW'(e1x) - AccW'(e0x)) <<< 8;
        end
        default: ;
      endcase
    end
    if (cmd.scan_en) begin
      if (col == w_eff - 1'b1) begin
        col <= '0;
        row <= row + 1'b1;
        nb <= nb_r + dnb_r;
        ng <= ng_r + dng_r;
        na <= na_r + dna_r;
        nb_r <= nb_r + dnb_r;
        ng_r <= ng_r + dng_r;
        na_r <= na_r + dna_r;
      end else begin
        col <= col + 1'b1;
        nb <= nb + dnb_c;
        ng <= ng + dng_c;
        na <= na + dna_c;
      end
    end
    if (cmd.setup_en && cmd.step == SetupLast) begin
      col <= '0;
      row <= '0;
    end
  end

  // pixel address: sweeps the store while clearing, walks the frame while scanning
  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (cmd.clear_en || cmd.scan_en) begin
      pix <= pix + 1'b1;
    end else if (cmd.setup_en) begin
      pix <= '0;
    end
  end

  assign ram_we = cmd.clear_en || (cmd.scan_en && covered);
  assign in_range = 32'(ridx) < Store;

  trc_ram #(.WIDTH(1), .DEPTH(RamDepth)) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pix),
    .wdata (cmd.scan_en),
    .raddr (AddrW'(32'(ridx))),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      reply_kind <= cmd_q;
      pixel_lit <= (cmd_q == CmdRead) && in_range && ram_q;
    end
  end

  assign status.clear_last = (32'(pix) == Store - 1);
  assign status.degenerate = (d == '0);
  assign status.scan_last = (col == w_eff - 1'b1) && (row == h_eff - 1'b1);
  assign status.out_free = !out_valid || !out_stall;
endmodule

// ----- rtl/triangle_coverage_rasterizer.sv -----
// Sequence: a read goes through the READ and FINISH states to its result; a draw runs
//   15 setup steps on one shared multiplier, then scans one pixel per cycle over the
//   frame before FINISH (degenerate draws skip the scan).
// Requests: one at a time; the next is taken only after the result is handed off.
// Reset: synchronous; sizes return to 256 and the frame store is swept to black,
//   one pixel per cycle over all MAX_FRAME_WIDTH*MAX_FRAME_HEIGHT entries, no requests taken.
module triangle_coverage_rasterizer import trc_pkg::*; #(
  parameter int MAX_FRAME_WIDTH = MaxFrameWidthDef,
  parameter int MAX_FRAME_HEIGHT = MaxFrameHeightDef
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic signed [15:0] vert_a_x,
  input  logic signed [15:0] vert_a_y,
  input  logic signed [15:0] vert_b_x,
  input  logic signed [15:0] vert_b_y,
  input  logic signed [15:0] vert_c_x,
  input  logic signed [15:0] vert_c_y,
  input  logic [15:0]        read_index,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               reply_kind,
  output logic               pixel_lit
);
  logic [CfgW-1:0] frame_width, frame_height;
  trc_cmd_t cmd;
  trc_status_t status;

  // Register file: width at 0x0, height at 0x4.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= CfgW'(256);
      frame_height <= CfgW'(256);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegWidth) frame_width <= pwdata[CfgW-1:0];
      else frame_height <= pwdata[CfgW-1:0];
    end
  end
  assign prdata = (paddr[2] == RegWidth) ? 32'(frame_width) : 32'(frame_height);

  // Sequencer: clear sweep, setup steps, pixel scan, result hand-off.
  trc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Vertex mapping, edge functions, frame store and result register.
  trc_dp #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .command      (command),
    .vert_a_x     (vert_a_x),
    .vert_a_y     (vert_a_y),
    .vert_b_x     (vert_b_x),
    .vert_b_y     (vert_b_y),
    .vert_c_x     (vert_c_x),
    .vert_c_y     (vert_c_y),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reply_kind   (reply_kind),
    .pixel_lit    (pixel_lit)
  );

  // No request is taken while the store is being swept.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_en |-> in_stall) else $error("request taken during clear");
  // A loaded result shows up the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result lost");
  // Clear sweep and pixel scan never share the write port.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clear_en && cmd.scan_en)) else $error("write port conflict");
endmodule

// ----- tb/sv/tb_triangle_coverage_rasterizer.sv -----
`timescale 1ns / 1ps

module tb_triangle_coverage_rasterizer;
  import trc_pkg::*;

  localparam int StoreSize = MaxFrameWidthDef * MaxFrameHeightDef;

  // clock / reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // config port
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // request / result channels
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CmdDraw;
  logic signed [15:0] vert_a_x = '0, vert_a_y = '0, vert_b_x = '0;
  logic signed [15:0] vert_b_y = '0, vert_c_x = '0, vert_c_y = '0;
  logic [15:0]        read_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               reply_kind;
  logic               pixel_lit;

  triangle_coverage_rasterizer dut (.*);

  typedef struct {
    logic kind;
    logic lit;
  } reply_t;

  // predictor state: shadow coverage store and size registers
  logic        shadow_frame [StoreSize];
  logic [8:0]  shadow_width;
  logic [8:0]  shadow_height;
  reply_t      expected_replies[$];

  int mismatches = 0;
  int draws_sent = 0, reads_sent = 0, lit_reads = 0;
  int idle_mode = 0;   // 0 none, 1 sender gaps, 2 receiver stalls, 3 both

  initial begin
    forever #2 clk = ~clk;
  end

  // safety net, well beyond the slowest legal run
  initial begin
    #12ms;
    $display("** triangle_coverage_rasterizer: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0b, expected %0b", $realtime, what, got, want);
  endtask

  function automatic longint clamp_size(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // NDC Q2.14 -> pixel space, 8 fraction bits, round half up
  function automatic longint ndc_to_px(input logic signed [15:0] ndc, input longint size);
    longint t;
    t = size * (16384 + longint'(ndc)) + 64;
    return (t >>> 7) - 128;
  endfunction

  // marks every covered pixel of the current frame in the shadow store
  task automatic rasterize_draw();
    longint w, h, ax, ay, bx, by, cx, cy, e0x, e0y, e1x, e1y, d, qx, qy, nb, ng, na;
    bit hit;
    w = clamp_size(shadow_width);
    h = clamp_size(shadow_height);
    ax = ndc_to_px(vert_a_x, w); ay = ndc_to_px(vert_a_y, h);
    bx = ndc_to_px(vert_b_x, w); by = ndc_to_px(vert_b_y, h);
    cx = ndc_to_px(vert_c_x, w); cy = ndc_to_px(vert_c_y, h);
    e0x = bx - ax; e0y = by - ay;
    e1x = cx - ax; e1y = cy - ay;
    d = e0x * e1y - e0y * e1x;
    if (d == 0) return;   // degenerate: nothing drawn
    for (longint r = 0; r < h; r++) begin
      for (longint c = 0; c < w; c++) begin
        qx = c * 256 - ax;
        qy = r * 256 - ay;
        nb = qx * e1y - qy * e1x;
        ng = e0x * qy - e0y * qx;
        na = d - nb - ng;
        hit = (d > 0) ? (nb >= 0 && ng >= 0 && na >= 0)
                      : (nb <= 0 && ng <= 0 && na <= 0);
        if (hit) shadow_frame[r * w + c] = 1'b1;
      end
    end
  endtask

  // one request: optional sender gap, then hold until accepted
  task automatic send_request(input logic cmd, input logic [15:0] v [6], input logic [15:0] idx);
    reply_t exp_r;
    if (idle_mode inside {1, 3}) begin
      while ($urandom_range(99) < 68) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    command = cmd;
    vert_a_x = v[0]; vert_a_y = v[1]; vert_b_x = v[2];
    vert_b_y = v[3]; vert_c_x = v[4]; vert_c_y = v[5];
    read_index = idx;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted: predict in acceptance order
    if (cmd == CmdDraw) begin
      rasterize_draw();
      exp_r = '{kind: 1'b0, lit: 1'b0};
      draws_sent++;
    end else begin
      exp_r.kind = 1'b1;
      exp_r.lit = (idx < StoreSize) ? shadow_frame[idx] : 1'b0;
      reads_sent++;
      if (exp_r.lit) lit_reads++;
    end
    expected_replies.push_back(exp_r);
    @(negedge clk);
  endtask

  // wait until every reply is in, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == 3'd0) shadow_width = data[8:0];
    else if (addr == 3'd4) shadow_height = data[8:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
    drain();
    apb_write(3'd0, w);
    apb_write(3'd4, h);
  endtask

  function automatic logic [15:0] rand_ndc(input bit wild);
    if (wild) return 16'($urandom());
    return 16'($urandom_range(32768) - 16384);   // inside [-1, 1]
  endfunction

  task automatic send_draw(input logic [15:0] ax, ay, bx, by, cx, cy);
    logic [15:0] v [6];
    v = '{ax, ay, bx, by, cx, cy};
    send_request(CmdDraw, v, 16'($urandom()));
  endtask

  task automatic send_read(input logic [15:0] idx);
    logic [15:0] v [6];
    foreach (v[i]) v[i] = 16'($urandom());
    send_request(CmdRead, v, idx);
  endtask

  // receiver back-pressure per idle phase
  always @(negedge clk) begin
    out_stall <= (idle_mode >= 2) && ($urandom_range(99) < 68);
  end

  // result checker
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("out_valid with nothing outstanding", 1'b1, 1'b0);
      end else begin
        want = expected_replies.pop_front();
        if (reply_kind !== want.kind) report_mismatch("reply_kind", reply_kind, want.kind);
        if (pixel_lit !== want.lit) report_mismatch("pixel_lit", pixel_lit, want.lit);
      end
    end
  end

  // full 256x256 frame at reset sizes: large triangle, degenerate, reads
  task automatic test_full_frame();
    send_read(16'd0);
    send_draw(16'shC000, 16'shC000, 16'sh4000, 16'shC000, 16'sh0000, 16'sh4000);
    send_read(16'd128 * 16'd256 + 16'd128);     // center, lit
    send_read(16'd0);                           // corner, lit
    send_read(16'hFFFF);                        // last entry
    // degenerate: collinear vertices
    send_draw(16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF);
    send_read(16'd255 * 16'd256 + 16'd255);
  endtask

  // out-of-range sizes clamp; tiny frames; extreme vertices
  task automatic test_size_clamp();
    set_frame(32'h1FF, 32'd0);                  // 256 x 1
    send_draw(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh8000);
    send_read(16'd3);
    send_read(16'd200);
    set_frame(32'd1, 32'd1);
    send_draw(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_draw(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_read(16'd0);
    set_frame(32'd7, 32'd3);
    send_draw(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_read(16'd20);
    send_read(16'd22);                          // beyond frame, inside store
    send_read(16'd6);
  endtask

  // random phase: mostly in-range triangles on small frames, some noise
  task automatic test_random(input int mode, input int count);
    logic [15:0] ax, ay;
    bit wild;
    idle_mode = 0;
    set_frame($urandom_range(24, 1), $urandom_range(24, 1));
    idle_mode = mode;
    repeat (count) begin
      wild = ($urandom_range(9) == 0);
      if ($urandom_range(2) != 0) begin
        ax = rand_ndc(wild);
        ay = rand_ndc(wild);
        if ($urandom_range(9) == 0)       // shared vertex -> degenerate
          send_draw(ax, ay, ax, ay, rand_ndc(wild), rand_ndc(wild));
        else
          send_draw(ax, ay, rand_ndc(wild), rand_ndc(wild), rand_ndc(wild), rand_ndc(wild));
      end else begin
        send_read(wild ? 16'($urandom())
                       : 16'($urandom_range(32'(clamp_size(shadow_width)
                                                * clamp_size(shadow_height) - 1))));
      end
    end
    drain();
  endtask

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = 1'b0;
    shadow_width = 9'd256;
    shadow_height = 9'd256;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_full_frame();
    test_size_clamp();
    test_random(0, 25);
    test_random(1, 25);
    test_random(2, 25);
    test_random(3, 25);

    $display("Covered %0d draws and %0d reads (%0d lit) over full, clamped and small frames,",
             draws_sent, reads_sent, lit_reads);
    $display("with sender gaps and result back-pressure in separate phases.");
    if (mismatches == 0) begin
      $display("** triangle_coverage_rasterizer: PASSED **");
    end else begin
      $display("** triangle_coverage_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/trc_pkg.sv
rtl/trc_ram.sv
rtl/trc_ctrl.sv
rtl/trc_dp.sv
rtl/triangle_coverage_rasterizer.sv
tb/sv/tb_triangle_coverage_rasterizer.sv
